// File: rtl/midpoint_ellipse_rasterizer_assert.svh
// Assertion macros for the ellipse rasterizer.
// Define NO_ASSERTIONS to compile them out.
`ifndef MIDPOINT_ELLIPSE_RASTERIZER_ASSERT_SVH
`define MIDPOINT_ELLIPSE_RASTERIZER_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication
`define MER_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("ellipse rasterizer: implication check failed");

// Next-cycle implication
`define MER_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("ellipse rasterizer: next-cycle check failed");

`else

`define MER_IMPLY(label, clk, rst_n, ante, cons)
`define MER_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// File: rtl/mer_pkg.sv
`default_nettype none

package mer_pkg;

    // Default field widths
    localparam int MER_COORD_BITS  = 16;
    localparam int MER_RADIUS_BITS = 12;

    // Input selector codes (s_tuser)
    localparam logic MODE_START = 1'b0;
    localparam logic MODE_STEP  = 1'b1;

    // Walk region
    typedef enum logic [1:0] {
        PH_DONE,
        PH_ONE,
        PH_TWO
    } phase_t;

    // Sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SQX,   // rx * rx
        ST_SQY,   // ry * ry
        ST_LX,    // rx2 * rx2
        ST_LY,    // ry2 * ry2
        ST_DI,    // rx2 * ry
        ST_DA,    // region one decision
        ST_T1,    // odd * odd
        ST_T2,    // odd^2 * (rx2 + ry2)
        ST_T3,    // bound compare
        ST_SW,    // region two decision
        ST_EMIT,  // push points
        ST_U1,    // walk update
        ST_U2,    // first decision product
        ST_U3,    // first decision add
        ST_U4     // second decision add
    } state_t;

    // Output stage control
    typedef struct packed {
        logic load;
        logic last;
        logic done;
    } out_ctl_t;

endpackage

`default_nettype wire

// File: rtl/mer_mul.sv
`default_nettype none

// Shared signed multiplier with registered product
module mer_mul
    import mer_pkg::*;
#(
    parameter int WIDTH = 2 * MER_RADIUS_BITS + 3
) (
    input  wire logic                      aclk,
    input  wire logic                      en,
    input  wire logic signed [WIDTH-1:0]   a,
    input  wire logic signed [WIDTH-1:0]   b,
    output logic signed [2*WIDTH-1:0]      prod_reg
);

    // Product register, loaded when the sequencer issues a multiply
    always_ff @(posedge aclk) begin
        if (en) begin
            prod_reg <= a * b;
        end
    end

endmodule

`default_nettype wire

// File: rtl/mer_out.sv
`default_nettype none

// One-entry output register on the result channel
module mer_out
    import mer_pkg::*;
#(
    parameter int COORD_BITS = MER_COORD_BITS
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire out_ctl_t                            ctl,
    input  wire logic [COORD_BITS-1:0]               px,
    input  wire logic [COORD_BITS-1:0]               py,
    output logic                                     free,
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    // point_x (low), point_y
    output logic [((2*COORD_BITS+7)/8)*8-1:0]        m_tdata,
    output logic                                     m_tlast,
    // done_res
    output logic                                     m_tuser
);

    localparam int OUT_W = ((2 * COORD_BITS + 7) / 8) * 8;

    logic                  valid_reg;
    logic [COORD_BITS-1:0] px_reg;
    logic [COORD_BITS-1:0] py_reg;
    logic                  last_reg;
    logic                  done_reg;

    // Slot can take a new result when empty or being drained
    assign free = !valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (ctl.load) begin
            valid_reg <= 1'b1;
        end else if (m_tready) begin
            valid_reg <= 1'b0;
        end
    end

    // Payload
    always_ff @(posedge aclk) begin
        if (ctl.load) begin
            px_reg   <= px;
            py_reg   <= py;
            last_reg <= ctl.last;
            done_reg <= ctl.done;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = OUT_W'({py_reg, px_reg});
    assign m_tlast  = last_reg;
    assign m_tuser  = done_reg;

endmodule

`default_nettype wire

// File: rtl/midpoint_ellipse_rasterizer.sv
// Midpoint ellipse rasterizer.
// Input channel (s_): s_tuser selects the transaction kind. A start transaction
// (s_tuser = 0) loads center and radii from s_tdata and produces no result. A step
// transaction (s_tuser = 1) produces four points (cx+x,cy+y), (cx-x,cy+y),
// (cx+x,cy-y), (cx-x,cy-y), the fourth with m_tlast set; once the shape is
// finished a step produces a single result with m_tuser (done) and m_tlast set
// and zero coordinates.
// All multiplies run through one shared registered multiplier under a small
// sequencer, so one transaction is handled at a time: s_tready is high only
// while the sequencer is idle.
// A start runs the setup states ST_SQX to ST_DA; a step runs the bound test
// (ST_T1 to ST_T3), ST_EMIT and the walk update (ST_U1 to ST_U3), with ST_SW on
// the step that enters region two and ST_U4 when the decision takes the diagonal
// move; a step that finishes the shape ends after ST_EMIT, and a step on a
// finished shape goes straight to ST_EMIT.
// Results leave through a one-entry output register; when m_tready is low the
// sequencer waits before pushing the next point, and after the last point it may
// accept the next transaction while that point is still waiting.
// Reset (aresetn low, synchronous) empties the output register and leaves the
// shape finished.
`default_nettype none
`include "midpoint_ellipse_rasterizer_assert.svh"

module midpoint_ellipse_rasterizer
    import mer_pkg::*;
#(
    parameter int COORD_BITS  = MER_COORD_BITS,
    parameter int RADIUS_BITS = MER_RADIUS_BITS
) (
    input  wire logic                                                  aclk,
    input  wire logic                                                  aresetn,
    input  wire logic                                                  s_tvalid,
    output logic                                                       s_tready,
    // center_x (low), center_y, radius_x, radius_y
    input  wire logic [((2*COORD_BITS+2*RADIUS_BITS+7)/8)*8-1:0]       s_tdata,
    // mode
    input  wire logic                                                  s_tuser,
    output logic                                                       m_tvalid,
    input  wire logic                                                  m_tready,
    // point_x (low), point_y
    output logic [((2*COORD_BITS+7)/8)*8-1:0]                          m_tdata,
    output logic                                                       m_tlast,
    // done_res
    output logic                                                       m_tuser
);

    localparam int CB     = COORD_BITS;
    localparam int RB     = RADIUS_BITS;
    localparam int WALK_W = RB + 2;
    localparam int SQ_W   = 2 * RB;
    localparam int SUM_W  = 2 * RB + 1;
    localparam int MUL_W  = 2 * RB + 3;
    localparam int PROD_W = 2 * MUL_W;
    localparam int LIM_W  = 4 * RB + 2;
    localparam int DEC_W  = 4 * RB + 8;
    localparam int XW     = CB + WALK_W;

    // Input fields
    logic [CB-1:0] in_cx;
    logic [CB-1:0] in_cy;
    logic [RB-1:0] in_rx;
    logic [RB-1:0] in_ry;

    assign in_cx = s_tdata[CB-1:0];
    assign in_cy = s_tdata[2*CB-1:CB];
    assign in_rx = s_tdata[2*CB+RB-1:2*CB];
    assign in_ry = s_tdata[2*CB+2*RB-1:2*CB+RB];

    state_t                    state_reg,  state_next;
    phase_t                    phase_reg,  phase_next;
    logic [1:0]                pt_idx_reg, pt_idx_next;
    logic                      diag_reg,   diag_next;
    logic [CB-1:0]             cx_reg,     cx_next;
    logic [CB-1:0]             cy_reg,     cy_next;
    logic [RB-1:0]             rx_reg,     rx_next;
    logic [RB-1:0]             ry_reg,     ry_next;
    logic [SQ_W-1:0]           rx2_reg,    rx2_next;
    logic [SQ_W-1:0]           ry2_reg,    ry2_next;
    logic [SUM_W-1:0]          sum_reg,    sum_next;
    logic [LIM_W-1:0]          lim_x_reg,  lim_x_next;
    logic [LIM_W-1:0]          lim_y_reg,  lim_y_next;
    logic [DEC_W-1:0]          dec_reg,    dec_next;
    logic signed [WALK_W-1:0]  wx_reg,     wx_next;
    logic signed [WALK_W-1:0]  wy_reg,     wy_next;

    // Multiplier interface
    logic                      mul_en;
    logic signed [MUL_W-1:0]   mul_a;
    logic signed [MUL_W-1:0]   mul_b;
    logic signed [PROD_W-1:0]  prod_reg;

    // Output stage interface
    out_ctl_t                  out_ctl;
    logic [CB-1:0]             out_px;
    logic [CB-1:0]             out_py;
    logic                      out_free;

    // Bound test helpers
    logic signed [WALK_W-1:0]  t_val;
    logic                      t_zero;
    logic [WALK_W:0]           odd;
    logic [LIM_W-1:0]          lim_sel;
    logic                      bound_ok;

    // Point helpers
    logic signed [XW-1:0]      wx_ext;
    logic signed [XW-1:0]      wy_ext;
    logic signed [XW-1:0]      dx;
    logic signed [XW-1:0]      dy;
    logic [XW-1:0]             sum_x;
    logic [XW-1:0]             sum_y;

    mer_mul #(
        .WIDTH (MUL_W)
    ) u_mul (
        .aclk     (aclk),
        .en       (mul_en),
        .a        (mul_a),
        .b        (mul_b),
        .prod_reg (prod_reg)
    );

    mer_out #(
        .COORD_BITS (CB)
    ) u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctl      (out_ctl),
        .px       (out_px),
        .py       (out_py),
        .free     (out_free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    // Bound test: t == 0 or (2t-1)^2 * (rx2+ry2) < 4 * a2^2
    assign t_val    = (phase_reg == PH_ONE) ? wx_reg : wy_reg;
    assign t_zero   = (t_val == '0);
    assign odd      = {t_val, 1'b0} - (WALK_W + 1)'(1);
    assign lim_sel  = (phase_reg == PH_ONE) ? lim_x_reg : lim_y_reg;
    assign bound_ok = t_zero || ($unsigned(prod_reg) < PROD_W'(lim_sel));

    // Symmetric point for the current index
    assign wx_ext = XW'(wx_reg);
    assign wy_ext = XW'(wy_reg);
    assign dx     = pt_idx_reg[0] ? -wx_ext : wx_ext;
    assign dy     = pt_idx_reg[1] ? -wy_ext : wy_ext;
    assign sum_x  = XW'(cx_reg) + dx;
    assign sum_y  = XW'(cy_reg) + dy;

    assign s_tready = (state_reg == ST_IDLE);

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            phase_reg  <= PH_DONE;
            pt_idx_reg <= '0;
        end else begin
            state_reg  <= state_next;
            phase_reg  <= phase_next;
            pt_idx_reg <= pt_idx_next;
        end
    end

    // Shape and walk registers
    always_ff @(posedge aclk) begin
        diag_reg  <= diag_next;
        cx_reg    <= cx_next;
        cy_reg    <= cy_next;
        rx_reg    <= rx_next;
        ry_reg    <= ry_next;
        rx2_reg   <= rx2_next;
        ry2_reg   <= ry2_next;
        sum_reg   <= sum_next;
        lim_x_reg <= lim_x_next;
        lim_y_reg <= lim_y_next;
        dec_reg   <= dec_next;
        wx_reg    <= wx_next;
        wy_reg    <= wy_next;
    end

    // Sequencer
    always_comb begin
        state_next  = state_reg;
        phase_next  = phase_reg;
        pt_idx_next = pt_idx_reg;
        diag_next   = diag_reg;
        cx_next     = cx_reg;
        cy_next     = cy_reg;
        rx_next     = rx_reg;
        ry_next     = ry_reg;
        rx2_next    = rx2_reg;
        ry2_next    = ry2_reg;
        sum_next    = sum_reg;
        lim_x_next  = lim_x_reg;
        lim_y_next  = lim_y_reg;
        dec_next    = dec_reg;
        wx_next     = wx_reg;
        wy_next     = wy_reg;
        mul_en      = 1'b0;
        mul_a       = '0;
        mul_b       = '0;
        out_ctl     = '0;
        out_px      = '0;
        out_py      = '0;

        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    if (s_tuser == MODE_START) begin
                        cx_next    = in_cx;
                        cy_next    = in_cy;
                        rx_next    = in_rx;
                        ry_next    = in_ry;
                        wx_next    = '0;
                        wy_next    = WALK_W'(in_ry);
                        state_next = ST_SQX;
                    end else if (phase_reg == PH_DONE) begin
                        state_next = ST_EMIT;
                    end else begin
                        state_next = ST_T1;
                    end
                end
            end

            // Setup products for a new shape
            ST_SQX: begin
                mul_en     = 1'b1;
                mul_a      = MUL_W'(rx_reg);
                mul_b      = MUL_W'(rx_reg);
                state_next = ST_SQY;
            end
            ST_SQY: begin
                rx2_next   = prod_reg[SQ_W-1:0];
                mul_en     = 1'b1;
                mul_a      = MUL_W'(ry_reg);
                mul_b      = MUL_W'(ry_reg);
                state_next = ST_LX;
            end
            ST_LX: begin
                ry2_next   = prod_reg[SQ_W-1:0];
                sum_next   = SUM_W'(rx2_reg) + SUM_W'(prod_reg[SQ_W-1:0]);
                mul_en     = 1'b1;
                mul_a      = MUL_W'(rx2_reg);
                mul_b      = MUL_W'(rx2_reg);
                state_next = ST_LY;
            end
            ST_LY: begin
                lim_x_next = {prod_reg[LIM_W-3:0], 2'b00};
                mul_en     = 1'b1;
                mul_a      = MUL_W'(ry2_reg);
                mul_b      = MUL_W'(ry2_reg);
                state_next = ST_DI;
            end
            ST_DI: begin
                lim_y_next = {prod_reg[LIM_W-3:0], 2'b00};
                mul_en     = 1'b1;
                mul_a      = MUL_W'(rx2_reg);
                mul_b      = MUL_W'(ry_reg);
                state_next = ST_DA;
            end
            ST_DA: begin
                // ry2 - rx2*ry + floor(rx2/4)
                dec_next   = DEC_W'(ry2_reg) - DEC_W'(prod_reg) + DEC_W'(rx2_reg >> 2);
                phase_next = (rx_reg == '0 || ry_reg == '0) ? PH_DONE : PH_ONE;
                state_next = ST_IDLE;
            end

            // Region bound test
            ST_T1: begin
                mul_en     = 1'b1;
                mul_a      = MUL_W'(odd);
                mul_b      = MUL_W'(odd);
                state_next = ST_T2;
            end
            ST_T2: begin
                mul_en     = 1'b1;
                mul_a      = prod_reg[MUL_W-1:0];
                mul_b      = MUL_W'(sum_reg);
                state_next = ST_T3;
            end
            ST_T3: begin
                if (bound_ok) begin
                    state_next = ST_EMIT;
                end else if (phase_reg == PH_ONE) begin
                    // Enter region two at (rx, 0); its first test always passes
                    phase_next = PH_TWO;
                    wx_next    = WALK_W'(rx_reg);
                    wy_next    = '0;
                    mul_en     = 1'b1;
                    mul_a      = MUL_W'(ry2_reg);
                    mul_b      = MUL_W'(rx_reg);
                    state_next = ST_SW;
                end else begin
                    phase_next = PH_DONE;
                    state_next = ST_EMIT;
                end
            end
            ST_SW: begin
                // rx2 - ry2*rx + floor(ry2/4)
                dec_next   = DEC_W'(rx2_reg) - DEC_W'(prod_reg) + DEC_W'(ry2_reg >> 2);
                state_next = ST_EMIT;
            end

            // Push results into the output register
            ST_EMIT: begin
                if (out_free) begin
                    out_ctl.load = 1'b1;
                    if (phase_reg == PH_DONE) begin
                        out_ctl.last = 1'b1;
                        out_ctl.done = 1'b1;
                        state_next   = ST_IDLE;
                    end else begin
                        out_px       = sum_x[CB-1:0];
                        out_py       = sum_y[CB-1:0];
                        out_ctl.last = (pt_idx_reg == 2'd3);
                        pt_idx_next  = pt_idx_reg + 2'd1;
                        if (pt_idx_reg == 2'd3) begin
                            state_next = ST_U1;
                        end
                    end
                end
            end

            // Walk update: axial move when the decision is negative
            ST_U1: begin
                diag_next = !dec_reg[DEC_W-1];
                if (phase_reg == PH_ONE) begin
                    wx_next = wx_reg + WALK_W'(1);
                    if (!dec_reg[DEC_W-1]) begin
                        wy_next = wy_reg - WALK_W'(1);
                    end
                end else begin
                    wy_next = wy_reg + WALK_W'(1);
                    if (!dec_reg[DEC_W-1]) begin
                        wx_next = wx_reg - WALK_W'(1);
                    end
                end
                state_next = ST_U2;
            end
            ST_U2: begin
                mul_en = 1'b1;
                if (phase_reg == PH_ONE) begin
                    mul_a = MUL_W'(ry2_reg);
                    mul_b = MUL_W'(wx_reg);
                end else begin
                    mul_a = MUL_W'(rx2_reg);
                    mul_b = MUL_W'(wy_reg);
                end
                state_next = ST_U3;
            end
            ST_U3: begin
                if (phase_reg == PH_ONE) begin
                    dec_next = dec_reg + (DEC_W'(prod_reg) << 1) + DEC_W'(ry2_reg);
                end else begin
                    dec_next = dec_reg + (DEC_W'(prod_reg) << 1) + DEC_W'(rx2_reg);
                end
                if (diag_reg) begin
                    mul_en = 1'b1;
                    if (phase_reg == PH_ONE) begin
                        mul_a = MUL_W'(rx2_reg);
                        mul_b = MUL_W'(wy_reg);
                    end else begin
                        mul_a = MUL_W'(ry2_reg);
                        mul_b = MUL_W'(wx_reg);
                    end
                    state_next = ST_U4;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_U4: begin
                dec_next   = dec_reg - (DEC_W'(prod_reg) << 1);
                state_next = ST_IDLE;
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Checks
    `MER_IMPLY(a_done_is_last, aclk, aresetn, m_tvalid && m_tuser, m_tlast)
    `MER_IMPLY(a_done_zero_pt, aclk, aresetn, m_tvalid && m_tuser, m_tdata == '0)
    `MER_IMPLY(a_one_x_nonneg, aclk, aresetn, phase_reg == PH_ONE, !wx_reg[WALK_W-1])
    `MER_IMPLY(a_two_y_nonneg, aclk, aresetn, phase_reg == PH_TWO, !wy_reg[WALK_W-1])
    `MER_NEXT(a_busy_after_accept, aclk, aresetn, s_tvalid && s_tready, !s_tready)

endmodule

`default_nettype wire

// File: sim/ellipse_checker.sv
`timescale 1ns / 1ps

// Watches both channels of the ellipse rasterizer, predicts the plotted points
// of every accepted step and compares them with the result transactions.
module ellipse_checker
    import mer_pkg::*;
#(
    parameter int IN_W  = ((2*MER_COORD_BITS+2*MER_RADIUS_BITS+7)/8)*8,
    parameter int OUT_W = ((2*MER_COORD_BITS+7)/8)*8
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_tvalid,
    input  wire logic             s_tready,
    input  wire logic [IN_W-1:0]  s_tdata,
    input  wire logic             s_tuser,
    input  wire logic             m_tvalid,
    input  wire logic             m_tready,
    input  wire logic [OUT_W-1:0] m_tdata,
    input  wire logic             m_tlast,
    input  wire logic             m_tuser,
    output int                    errors,
    output int                    pending
);

    localparam int CW = MER_COORD_BITS;
    localparam int RW = MER_RADIUS_BITS;

    typedef struct packed {
        logic [CW-1:0] px;
        logic [CW-1:0] py;
        logic          last;
        logic          done;
    } pixel_t;

    pixel_t points_due[$];
    int     fail_count = 0;
    int     due_count  = 0;

    assign errors  = fail_count;
    assign pending = due_count;

    // Predicted walk state
    phase_t        region;
    logic [63:0]   walk_x;
    logic [63:0]   walk_y;
    logic [63:0]   decision;
    logic [63:0]   rx_sq;
    logic [63:0]   ry_sq;
    logic [CW-1:0] org_x;
    logic [CW-1:0] org_y;
    logic [RW-1:0] semi_x;
    logic [RW-1:0] semi_y;

    // Exact region bound: t == 0 or (2t-1)^2 * (a2+b2) < 4*a2^2
    function automatic bit bound_holds(logic [63:0] t, logic [63:0] a2, logic [63:0] b2);
        logic [63:0]  odd;
        logic [63:0]  odd_sq;
        logic [63:0]  sum_sq;
        logic [63:0]  quad;
        logic [127:0] lhs;
        logic [127:0] rhs;
        if (t == 64'd0)
            return 1'b1;
        odd    = 64'd2 * t - 64'd1;
        odd_sq = odd * odd;
        sum_sq = a2 + b2;
        quad   = 64'd4 * a2;
        lhs    = {64'd0, odd_sq} * {64'd0, sum_sq};
        rhs    = {64'd0, quad} * {64'd0, a2};
        return lhs < rhs;
    endfunction

    function automatic void queue_point(logic [CW-1:0] px, logic [CW-1:0] py,
                                        logic last, logic done);
        pixel_t p;
        p.px   = px;
        p.py   = py;
        p.last = last;
        p.done = done;
        points_due.push_back(p);
    endfunction

    function automatic bit field_ok(string name, logic [CW-1:0] want, logic [CW-1:0] got);
        if (want === got)
            return 1'b1;
        $display("%0t: %s mismatch: expected %0d, got %0d",
                 $time, name, $signed(want), $signed(got));
        return 1'b0;
    endfunction

    function automatic void clear_shape();
        region   = PH_DONE;
        walk_x   = '0;
        walk_y   = '0;
        decision = '0;
        rx_sq    = '0;
        ry_sq    = '0;
        org_x    = '0;
        org_y    = '0;
        semi_x   = '0;
        semi_y   = '0;
    endfunction

    // Start transaction: latch center and radii, set up region one
    function automatic void load_shape(logic [IN_W-1:0] d);
        org_x    = d[CW-1:0];
        org_y    = d[2*CW-1:CW];
        semi_x   = d[2*CW+RW-1:2*CW];
        semi_y   = d[2*CW+2*RW-1:2*CW+RW];
        rx_sq    = 64'(semi_x) * 64'(semi_x);
        ry_sq    = 64'(semi_y) * 64'(semi_y);
        walk_x   = '0;
        walk_y   = 64'(semi_y);
        decision = ry_sq - rx_sq * 64'(semi_y) + (rx_sq >> 2);
        region   = (semi_x == '0 || semi_y == '0) ? PH_DONE : PH_ONE;
    endfunction

    // Step transaction: emit one iteration, then move the walk
    function automatic void advance_walk();
        logic [CW-1:0] xp;
        logic [CW-1:0] xm;
        logic [CW-1:0] yp;
        logic [CW-1:0] ym;
        if (region == PH_ONE && !bound_holds(walk_x, rx_sq, ry_sq)) begin
            region   = PH_TWO;
            walk_x   = 64'(semi_x);
            walk_y   = '0;
            decision = rx_sq - ry_sq * 64'(semi_x) + (ry_sq >> 2);
        end
        if (region == PH_TWO && !bound_holds(walk_y, ry_sq, rx_sq))
            region = PH_DONE;

        if (region == PH_DONE) begin
            queue_point('0, '0, 1'b1, 1'b1);
        end else begin
            xp = org_x + walk_x[CW-1:0];
            xm = org_x - walk_x[CW-1:0];
            yp = org_y + walk_y[CW-1:0];
            ym = org_y - walk_y[CW-1:0];
            queue_point(xp, yp, 1'b0, 1'b0);
            queue_point(xm, yp, 1'b0, 1'b0);
            queue_point(xp, ym, 1'b0, 1'b0);
            queue_point(xm, ym, 1'b1, 1'b0);

            if (region == PH_ONE) begin
                walk_x = walk_x + 64'd1;
                if (decision[63]) begin
                    decision = decision + 64'd2 * ry_sq * walk_x + ry_sq;
                end else begin
                    walk_y   = walk_y - 64'd1;
                    decision = decision + 64'd2 * ry_sq * walk_x
                               - 64'd2 * rx_sq * walk_y + ry_sq;
                end
            end else begin
                walk_y = walk_y + 64'd1;
                if (decision[63]) begin
                    decision = decision + 64'd2 * rx_sq * walk_y + rx_sq;
                end else begin
                    walk_x   = walk_x - 64'd1;
                    decision = decision + 64'd2 * rx_sq * walk_y
                               - 64'd2 * ry_sq * walk_x + rx_sq;
                end
            end
        end
    endfunction

    // Result check first, then prediction of the accepted input transaction
    always @(posedge aclk) begin : monitor
        pixel_t want;
        bit     ok;
        if (!aresetn) begin
            clear_shape();
            points_due.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                if (points_due.size() == 0) begin
                    $display("%0t: unexpected point: expected none, got x=%0d y=%0d last=%0b done=%0b",
                             $time, $signed(m_tdata[CW-1:0]), $signed(m_tdata[2*CW-1:CW]),
                             m_tlast, m_tuser);
                    fail_count <= fail_count + 1;
                end else begin
                    want = points_due.pop_front();
                    ok = field_ok("point_x", want.px, m_tdata[CW-1:0])
                       & field_ok("point_y", want.py, m_tdata[2*CW-1:CW])
                       & field_ok("last", CW'(want.last), CW'(m_tlast))
                       & field_ok("done_res", CW'(want.done), CW'(m_tuser));
                    if (!ok)
                        fail_count <= fail_count + 1;
                end
            end
            if (s_tvalid && s_tready) begin
                if (s_tuser == MODE_START)
                    load_shape(s_tdata);
                else
                    advance_walk();
            end
        end
        due_count <= points_due.size();
    end

endmodule

// File: sim/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import mer_pkg::*;

    localparam int CW          = MER_COORD_BITS;
    localparam int RW          = MER_RADIUS_BITS;
    localparam int IN_W        = ((2*CW+2*RW+7)/8)*8;
    localparam int OUT_W       = ((2*CW+7)/8)*8;
    localparam int ITEM_TARGET = 300;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN       = 50;

    logic            aclk     = 1'b0;
    logic            aresetn  = 1'b0;
    logic            s_tvalid = 1'b0;
    logic [IN_W-1:0] s_tdata  = '0;
    logic            s_tuser  = MODE_START;
    logic            m_tready = 1'b0;

    wire logic             s_tready;
    wire logic             m_tvalid;
    wire logic [OUT_W-1:0] m_tdata;
    wire logic             m_tlast;
    wire logic             m_tuser;

    int errors;
    int pending;
    int cycles         = 0;
    int items_sent     = 0;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;

    midpoint_ellipse_rasterizer u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    ellipse_checker u_check (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser),
        .errors   (errors),
        .pending  (pending)
    );

    initial begin
        forever #4 aclk = ~aclk;
    end

    // Watchdog
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // Result side back-pressure
    always @(posedge aclk) begin
        m_tready <= (recv_stall_pct == 0) || ($urandom_range(99) >= recv_stall_pct);
    end

    // One input transaction, with an optional idle gap in front
    task automatic send_item(input logic mode, input logic [CW-1:0] cx,
                             input logic [CW-1:0] cy, input logic [RW-1:0] rx,
                             input logic [RW-1:0] ry);
        if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < send_idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= {ry, rx, cy, cx};
        do @(posedge aclk); while (!s_tready);
        items_sent++;
    endtask

    // Start a shape and issue a number of steps with junk payload
    task automatic draw_shape(input logic [CW-1:0] cx, input logic [CW-1:0] cy,
                              input logic [RW-1:0] rx, input logic [RW-1:0] ry,
                              input int unsigned steps);
        send_item(MODE_START, cx, cy, rx, ry);
        repeat (steps)
            send_item(MODE_STEP, CW'($urandom), CW'($urandom), RW'($urandom), RW'($urandom));
    endtask

    initial begin
        int unsigned   pick;
        int unsigned   n_steps;
        int            first_random;
        int            stage;
        logic [RW-1:0] rx;
        logic [RW-1:0] ry;

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: step on a finished shape, zero radii, wrap at the extremes,
        // largest radii, a flat shape and a tall one that walks past the axis
        send_item(MODE_STEP, '1, '1, '1, '1);
        draw_shape(16'h0000, 16'h0000, 12'd0, 12'd5, 1);
        draw_shape(16'h0064, 16'hFF9C, 12'd3, 12'd0, 1);
        draw_shape(16'h7FFF, 16'h8000, 12'd1, 12'd1, 5);
        draw_shape(16'h8000, 16'h7FFF, 12'hFFF, 12'hFFF, 2);
        draw_shape(16'h0000, 16'h0000, 12'hFFF, 12'd1, 2);
        draw_shape(16'hFFFB, 16'h0007, 12'd1, 12'd6, 9);

        // Random shapes, mostly complete walks; idling changes every quarter
        first_random = items_sent;
        while (items_sent < first_random + ITEM_TARGET) begin
            stage = (items_sent - first_random) * 4 / ITEM_TARGET;
            case (stage)
                0: begin
                    send_idle_pct = 0;
                    recv_stall_pct <= 0;
                end
                1: begin
                    send_idle_pct = 80;
                    recv_stall_pct <= 0;
                end
                2: begin
                    send_idle_pct = 0;
                    recv_stall_pct <= 80;
                end
                default: begin
                    send_idle_pct = 20;
                    recv_stall_pct <= 20;
                end
            endcase

            pick = $urandom_range(99);
            rx   = RW'($urandom_range(1, 12));
            ry   = RW'($urandom_range(1, 12));
            if (pick < 70) begin
                // full walk plus a few steps on the finished shape
                n_steps = rx + ry + $urandom_range(3, 4);
                draw_shape(CW'($urandom), CW'($urandom), rx, ry, n_steps);
            end else if (pick < 82) begin
                // abandoned midway by a new start
                draw_shape(CW'($urandom), CW'($urandom), rx, ry, $urandom_range(0, rx));
            end else if (pick < 88) begin
                // empty shape
                if ($urandom_range(1)) begin
                    rx = '0;
                    ry = RW'($urandom);
                end else begin
                    rx = RW'($urandom);
                    ry = '0;
                end
                draw_shape(CW'($urandom), CW'($urandom), rx, ry, $urandom_range(1, 2));
            end else if (pick < 94) begin
                // any radii, only the first few iterations
                draw_shape(CW'($urandom), CW'($urandom), RW'($urandom), RW'($urandom),
                           $urandom_range(1, 4));
            end else begin
                // stray transaction of either kind
                send_item(1'($urandom), CW'($urandom), CW'($urandom), RW'($urandom),
                          RW'($urandom));
            end
        end
        s_tvalid <= 1'b0;

        // Drain outstanding points, then watch for strays
        @(posedge aclk);
        wait (pending == 0);
        repeat (DRAIN) @(posedge aclk);

        if (errors == 0 && pending == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

// File: filelist.f
+incdir+rtl
rtl/mer_pkg.sv
rtl/mer_mul.sv
rtl/mer_out.sv
rtl/midpoint_ellipse_rasterizer.sv
sim/ellipse_checker.sv
sim/testbench.sv
